>>> src/binary_min_heap_queue_assert.svh
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Same-cycle check: cons must hold whenever ante holds
`define HQ_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Next-cycle check: cons must hold in the cycle after ante
`define HQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

>>> src/hq_pkg.sv
package hq_pkg;

  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int ADDR_BITS    = $clog2(CAPACITY);
  localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
  // child index needs room for 2*pos+2
  localparam int CHILD_BITS   = ADDR_BITS + 2;

  localparam logic [0:0] CMD_INSERT = 1'b0;
  localparam logic [0:0] CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } hq_status_t;

  typedef struct packed {
    logic [0:0]              command;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } hq_item_t;

  typedef struct packed {
    hq_status_t              status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [COUNT_BITS-1:0]   fill_count;
  } hq_result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } hq_entry_t;

  // sequencer to heap memory
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    hq_entry_t            wdata;
    logic [ADDR_BITS-1:0] raddr_a;
    logic [ADDR_BITS-1:0] raddr_b;
  } hq_mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_TAKE,
    S_DN_RD,
    S_DN_CMP
  } hq_state_t;

endpackage

>>> src/hq_mem.sv
module hq_mem (
  input  logic               clk,
  input  hq_pkg::hq_mem_req_t req,
  output hq_pkg::hq_entry_t  rdata_a,
  output hq_pkg::hq_entry_t  rdata_b
);
  import hq_pkg::*;

  hq_entry_t heap [CAPACITY];

  // one write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      heap[req.waddr] <= req.wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= heap[req.raddr_a];
    rdata_b <= heap[req.raddr_b];
  end

endmodule

>>> src/hq_ctrl.sv
module hq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hq_pkg::hq_item_t    item,
  output logic                busy,
  output logic                done,
  output hq_pkg::hq_result_t  result,
  output hq_pkg::hq_mem_req_t mem_req,
  input  hq_pkg::hq_entry_t   rdata_a,
  input  hq_pkg::hq_entry_t   rdata_b
);
  import hq_pkg::*;

  hq_state_t             state, state_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [ADDR_BITS-1:0]  pos, pos_next;
  hq_entry_t             hold, hold_next;
  hq_result_t            res, res_next;
  logic                  done_next;

  logic [ADDR_BITS-1:0]  parent;
  logic [CHILD_BITS-1:0] left_idx, right_idx, count_wide;
  logic                  up_less, left_out, right_in, pick_right, dn_less;
  hq_entry_t             pick;
  logic [ADDR_BITS-1:0]  pick_idx;
  logic                  is_full, is_empty;

  // index arithmetic and the compare unit
  always_comb begin
    parent     = (pos - ADDR_BITS'(1)) >> 1;
    left_idx   = {1'b0, pos, 1'b1};
    right_idx  = left_idx + CHILD_BITS'(1);
    count_wide = CHILD_BITS'(count);
    left_out   = left_idx >= count_wide;
    right_in   = right_idx < count_wide;
    up_less    = hold.key < rdata_a.key;
    pick_right = right_in && (rdata_a.key > rdata_b.key);
    pick       = pick_right ? rdata_b : rdata_a;
    pick_idx   = pick_right ? right_idx[ADDR_BITS-1:0] : left_idx[ADDR_BITS-1:0];
    dn_less    = pick.key < hold.key;
    is_full    = count >= COUNT_BITS'(CAPACITY);
    is_empty   = count == '0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (item.command == CMD_INSERT) begin
            if (!is_full) state_next = S_UP_RD;
          end else if (!is_empty) begin
            state_next = S_DN_TAKE;
          end
        end
      end
      S_UP_RD: begin
        state_next = (pos == '0) ? S_IDLE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_next = up_less ? S_UP_RD : S_IDLE;
      end
      S_DN_TAKE: begin
        state_next = is_empty ? S_IDLE : S_DN_RD;
      end
      S_DN_RD: begin
        state_next = left_out ? S_IDLE : S_DN_CMP;
      end
      S_DN_CMP: begin
        state_next = dn_less ? S_DN_RD : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mem_req.we      = 1'b0;
    mem_req.waddr   = pos;
    mem_req.wdata   = hold;
    mem_req.raddr_a = '0;
    mem_req.raddr_b = ADDR_BITS'(count - COUNT_BITS'(1));
    count_next      = count;
    pos_next        = pos;
    hold_next       = hold;
    res_next        = res;
    done_next       = 1'b0;
    case (state)
      S_IDLE: begin
        // root and last word are read here so a remove can start at once
        if (start) begin
          if (item.command == CMD_INSERT) begin
            if (is_full) begin
              res_next  = '{ST_FULL, '0, '0, count};
              done_next = 1'b1;
            end else begin
              pos_next   = count[ADDR_BITS-1:0];
              hold_next  = '{item.key, item.payload};
              count_next = count + COUNT_BITS'(1);
            end
          end else begin
            if (is_empty) begin
              res_next  = '{ST_EMPTY, '0, '0, count};
              done_next = 1'b1;
            end else begin
              count_next = count - COUNT_BITS'(1);
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          mem_req.we = 1'b1;
          res_next   = '{ST_INSERTED, '0, '0, count};
          done_next  = 1'b1;
        end else begin
          mem_req.raddr_a = parent;
        end
      end
      S_UP_CMP: begin
        mem_req.we = 1'b1;
        if (up_less) begin
          // parent moves down, hole moves up
          mem_req.wdata = rdata_a;
          pos_next      = parent;
        end else begin
          res_next  = '{ST_INSERTED, '0, '0, count};
          done_next = 1'b1;
        end
      end
      S_DN_TAKE: begin
        res_next  = '{ST_REMOVED, rdata_a.key, rdata_a.payload, count};
        hold_next = rdata_b;
        pos_next  = '0;
        done_next = is_empty;
      end
      S_DN_RD: begin
        mem_req.raddr_a = left_idx[ADDR_BITS-1:0];
        mem_req.raddr_b = right_idx[ADDR_BITS-1:0];
        if (left_out) begin
          mem_req.we = 1'b1;
          done_next  = 1'b1;
        end
      end
      S_DN_CMP: begin
        mem_req.we = 1'b1;
        if (dn_less) begin
          // smaller child moves up, hole moves down
          mem_req.wdata = pick;
          pos_next      = pick_idx;
        end else begin
          done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    hold <= hold_next;
    res  <= res_next;
  end

  assign busy   = state != S_IDLE;
  assign result = res;

endmodule

>>> src/binary_min_heap_queue.sv
// Full or empty answers strobe done in the cycle after start; an insert or a
// remove walks the heap level by level, a read and then a compare per level.
// Throughput: one word at a time; start is taken again in the done cycle.
// Reset empties the queue; entry storage is not cleared. Results cannot stall.
module binary_min_heap_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  hq_pkg::hq_item_t   item,
  output logic               busy,
  output logic               done,
  output hq_pkg::hq_result_t result
);
  import hq_pkg::*;

  hq_mem_req_t mem_req;
  hq_entry_t   rdata_a, rdata_b;

  hq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .mem_req (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  hq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

`include "binary_min_heap_queue_assert.svh"

  `HQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done)
  `HQ_ASSERT_SAME(a_done_idle, done, !busy)
  `HQ_ASSERT_SAME(a_fill_cap, done, result.fill_count <= COUNT_BITS'(CAPACITY))
  `HQ_ASSERT_SAME(a_empty_zero, done && result.status == ST_EMPTY, result.fill_count == '0)

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hq_pkg::*;

  localparam int RANDOM_WORDS = 2000;
  localparam int TAIL_CYCLES  = 2 * ADDR_BITS + 8;

  // one row of the directed table; count > 1 repeats the row with the key
  // stepped by key_step and the payload stepped by one
  typedef struct {
    logic [0:0]              command;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    int                      count;
    int                      key_step;
    bit                      has_exp;
    hq_result_t              exp;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  hq_item_t   item;
  logic       busy;
  logic       done;
  hq_result_t result;

  // typed expectation that rides along with the word being offered
  bit         word_has_exp;
  hq_result_t word_exp;

  // predictor state: heap entries and fill level
  hq_entry_t  heap_mem [CAPACITY];
  int         heap_fill;

  hq_result_t pending_results [$];
  int         err_count;
  int         inserted_seen, removed_seen, empty_seen, full_seen;
  int         peak_fill;

  binary_min_heap_queue u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10ms;
    $display("binary_min_heap_queue regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 30) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // apply one word to the predicted heap and return the result it causes
  function automatic hq_result_t heap_apply(hq_item_t w);
    hq_result_t r;
    hq_entry_t  tmp;
    int         pos, up, lc, rc, pick;
    r = '0;
    if (w.command == CMD_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_mem[heap_fill] = '{key: w.key, payload: w.payload};
        pos = heap_fill;
        heap_fill++;
        // sift up while strictly less than the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_mem[pos].key < heap_mem[up].key)) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[up];
          heap_mem[up] = tmp;
          pos = up;
        end
        r.status = ST_INSERTED;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_REMOVED;
        r.out_key = heap_mem[0].key;
        r.out_payload = heap_mem[0].payload;
        heap_fill--;
        heap_mem[0] = heap_mem[heap_fill];
        // sift down: left child wins a tie, swap only when strictly less
        pos = 0;
        forever begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          if (lc >= heap_fill) break;
          pick = lc;
          if (rc < heap_fill && heap_mem[lc].key > heap_mem[rc].key) pick = rc;
          if (!(heap_mem[pick].key < heap_mem[pos].key)) break;
          tmp = heap_mem[pick];
          heap_mem[pick] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = pick;
        end
      end
    end
    r.fill_count = COUNT_BITS'(heap_fill);
    return r;
  endfunction

  // check strobed results, then log the word taken at this edge
  always @(posedge clk) begin
    hq_result_t exp_r;
    hq_result_t pred;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", result));
        end else begin
          exp_r = pending_results.pop_front();
          if (result.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      result.status, exp_r.status));
          if (result.out_key !== exp_r.out_key)
            report_mismatch($sformatf("out_key %h, expected %h",
                                      result.out_key, exp_r.out_key));
          if (result.out_payload !== exp_r.out_payload)
            report_mismatch($sformatf("out_payload %h, expected %h",
                                      result.out_payload, exp_r.out_payload));
          if (result.fill_count !== exp_r.fill_count)
            report_mismatch($sformatf("fill_count %0d, expected %0d",
                                      result.fill_count, exp_r.fill_count));
          case (exp_r.status)
            ST_INSERTED: inserted_seen++;
            ST_REMOVED:  removed_seen++;
            ST_EMPTY:    empty_seen++;
            default:     full_seen++;
          endcase
          if (int'(exp_r.fill_count) > peak_fill) peak_fill = int'(exp_r.fill_count);
        end
      end
      if (start && !busy) begin
        pred = heap_apply(item);
        pending_results.push_back(word_has_exp ? word_exp : pred);
      end
    end
  end

  // offer one word, optionally after a random gap, and hold it until taken
  task automatic send_word(input hq_item_t w, input bit has_e, input hq_result_t e,
                           input bit may_idle);
    if (may_idle && $urandom_range(99) < 17) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    word_has_exp <= has_e;
    word_exp <= e;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    stim_row_t  dir_table [19];
    hq_item_t   w;
    int         burst_left;
    int         insert_pct;
    int         pick;
    bit         may_idle;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    word_has_exp = 1'b0;
    word_exp = '0;
    heap_fill = 0;
    err_count = 0;
    inserted_seen = 0;
    removed_seen = 0;
    empty_seen = 0;
    full_seen = 0;
    peak_fill = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;

    dir_table = '{
      // remove right after reset finds nothing
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 7'd0}},
      // key and payload extremes
      '{CMD_INSERT, 16'hFFFF, 16'hFFFF, 1, 0, 1'b1, '{ST_INSERTED, 16'h0, 16'h0, 7'd1}},
      '{CMD_INSERT, 16'h0000, 16'h0000, 1, 0, 1'b1, '{ST_INSERTED, 16'h0, 16'h0, 7'd2}},
      // key and payload of a remove word are don't-care
      '{CMD_REMOVE, 16'hFFFF, 16'hFFFF, 1, 0, 1'b1, '{ST_REMOVED, 16'h0, 16'h0, 7'd1}},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1,
        '{ST_REMOVED, 16'hFFFF, 16'hFFFF, 7'd0}},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 7'd0}},
      // equal keys, then a smaller one, then ascending keys
      '{CMD_INSERT, 16'h1234, 16'h0001, 4, 0, 1'b0, '0},
      '{CMD_INSERT, 16'h1233, 16'h0100, 1, 0, 1'b0, '0},
      '{CMD_INSERT, 16'h8000, 16'hAAAA, 3, 1, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 8, 0, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 7'd0}},
      // descending keys: every insert climbs to the root, ends full
      '{CMD_INSERT, 16'hFF00, 16'h5555, 64, -256, 1'b0, '0},
      '{CMD_INSERT, 16'h0000, 16'hFFFF, 1, 0, 1'b1, '{ST_FULL, 16'h0, 16'h0, 7'd64}},
      '{CMD_INSERT, 16'hFFFF, 16'h0000, 1, 0, 1'b1, '{ST_FULL, 16'h0, 16'h0, 7'd64}},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1,
        '{ST_REMOVED, 16'hC000, 16'h5594, 7'd63}},
      '{CMD_INSERT, 16'h0000, 16'h0001, 1, 0, 1'b1, '{ST_INSERTED, 16'h0, 16'h0, 7'd64}},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1,
        '{ST_REMOVED, 16'h0000, 16'h0001, 7'd63}},
      // drain the rest through the full sift-down depth
      '{CMD_REMOVE, 16'h0000, 16'h0000, 63, 0, 1'b0, '0},
      '{CMD_REMOVE, 16'h0000, 16'h0000, 1, 0, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 7'd0}}
    };

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (dir_table[r]) begin
      for (int i = 0; i < dir_table[r].count; i++) begin
        w.command = dir_table[r].command;
        w.key = KEY_BITS'(int'(dir_table[r].key) + i * dir_table[r].key_step);
        w.payload = PAYLOAD_BITS'(int'(dir_table[r].payload) + i);
        send_word(w, dir_table[r].has_exp, dir_table[r].exp, 1'b1);
      end
    end

    // random words in bursts that lean toward filling, draining or neither
    burst_left = 0;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 120);
        case ($urandom_range(2))
          0:       insert_pct = 90;
          1:       insert_pct = 10;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      w.command = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      pick = $urandom_range(99);
      if (pick < 60)      w.key = KEY_BITS'($urandom);
      else if (pick < 85) w.key = KEY_BITS'($urandom_range(7));
      else if (pick < 95) w.key = 16'hFFF8 + KEY_BITS'($urandom_range(7));
      else                w.key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      w.payload = PAYLOAD_BITS'($urandom);
      // back-to-back stretch with no gaps
      may_idle = !(n >= 800 && n < 1200);
      send_word(w, 1'b0, '0, may_idle);
    end

    @(negedge clk);
    start <= 1'b0;
    word_has_exp <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered: %0d inserts, %0d removes, %0d empty removes, %0d full inserts",
             inserted_seen, removed_seen, empty_seen, full_seen);
    $display("peak fill %0d of %0d, mismatches %0d", peak_fill, CAPACITY, err_count);
    if (err_count == 0) begin
      $display("binary_min_heap_queue regression: pass");
    end else begin
      $display("binary_min_heap_queue regression: fail");
    end
    $finish;
  end

endmodule
